[src/mcc_pkg.sv]
`default_nettype none
package mcc_pkg;
  localparam int MAX_WIDTH_D    = 256;
  localparam int MAX_HEIGHT_D   = 256;
  localparam int MAX_KSIZE_D    = 7;
  localparam int MAX_CHANNELS_D = 4;
  localparam int SAMPLE_BITS_D  = 16;
  localparam int SUM_BITS       = 40;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 9;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_KSIZE    = 2'd2,
    REG_CHANNELS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // sequencer to datapath control
  typedef struct packed {
    logic clear;
    logic mac_en;
  } mac_ctl_t;
endpackage
`default_nettype wire

[src/mcc_if.sv]
`default_nettype none
interface mcc_stream_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcc_cfg_if #(parameter int IW = 2, parameter int DW = 9);
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[src/mcc_mac.sv]
`default_nettype none
module mcc_mac
  import mcc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  wire logic                          clk,
  input  wire mac_ctl_t                      ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  output      logic signed [SUM_BITS-1:0]    acc
);
  logic signed [2*SAMPLE_BITS-1:0] prod;

  // product registered before accumulation
  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.mac_en) begin
      acc <= acc + SUM_BITS'(prod);
    end
  end
endmodule
`default_nettype wire

[src/multichannel_conv2d_core.sv]
// multichannel_conv2d_core: one output map of a valid, stride-1 multichannel
// 2D cross-correlation.
// in channel (valid/ready): mode, value, first, weight_channel/row/col.
//   mode=1 writes a kernel weight (no result).
//   mode=0 stores a pixel sample; pixels arrive raster order, channel fastest.
// cfg channel: index 0..3 = width, height, kernel size, channel count; any
//   write to those restarts the frame position. Write only while idle.
// out channel: conv_sum, out_row, out_col, frame_end, one per completed window.
// A pixel that completes a window is summed over its nc*K*K taps by the
//   single multiply-accumulate; other items are taken while the block is idle.
//   One item is in flight at a time; ready is low meanwhile.
// The line store (MAX_KSIZE rows) and weight store are memories with one
// registered read port each; they need no clearing.
// Reset clears the position counters and returns registers to 256/256/3/1.
// A stalled receiver holds the result in the output register, and the block
// takes no new item until it is taken.
`default_nettype none
module multichannel_conv2d_core
  import mcc_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_D,
  parameter int MAX_HEIGHT   = MAX_HEIGHT_D,
  parameter int MAX_KSIZE    = MAX_KSIZE_D,
  parameter int MAX_CHANNELS = MAX_CHANNELS_D,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_D
) (
  input wire logic clk,
  input wire logic rst,
  mcc_stream_if.sink   in_ch,
  mcc_stream_if.source out_ch,
  mcc_cfg_if.sink      cfg
);
  localparam int CB  = $clog2(MAX_WIDTH + 1);
  localparam int RB  = $clog2(MAX_HEIGHT + 1);
  localparam int KB  = $clog2(MAX_KSIZE + 1);
  localparam int NB  = $clog2(MAX_CHANNELS + 1);
  localparam int LRB = (MAX_KSIZE > 1) ? $clog2(MAX_KSIZE) : 1;
  localparam int LDEPTH = MAX_KSIZE * MAX_WIDTH * MAX_CHANNELS;
  localparam int WDEPTH = MAX_CHANNELS * MAX_KSIZE * MAX_KSIZE;
  localparam int LAB = $clog2(LDEPTH);
  localparam int WAB = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  // payload unpack (mode, value, first, wch[2], wrow[3], wcol[3])
  logic                          mode, first;
  logic signed [15:0]            value;
  logic [1:0]                    wch;
  logic [2:0]                    wrw, wcl;
  assign {mode, value, first, wch, wrw, wcl} = in_ch.data;

  logic [8:0] image_width, image_height;
  logic [2:0] kernel_side, channel_count;
  logic [CB-1:0] wcfg;
  logic [RB-1:0] hcfg;
  logic [KB-1:0] kcfg;
  logic [NB-1:0] ncfg;

  always_comb begin
    wcfg = (image_width == 0) ? CB'(1) :
           (32'(image_width) > MAX_WIDTH) ? CB'(MAX_WIDTH) : CB'(image_width);
    hcfg = (image_height == 0) ? RB'(1) :
           (32'(image_height) > MAX_HEIGHT) ? RB'(MAX_HEIGHT) : RB'(image_height);
    kcfg = (kernel_side == 0) ? KB'(1) :
           (32'(kernel_side) > MAX_KSIZE) ? KB'(MAX_KSIZE) : KB'(kernel_side);
    ncfg = (channel_count == 0) ? NB'(1) :
           (32'(channel_count) > MAX_CHANNELS) ? NB'(MAX_CHANNELS) : NB'(channel_count);
  end

  state_t state, state_next;

  logic [RB-1:0] row_count;
  logic [CB-1:0] col_count;
  logic [NB-1:0] chan_count;
  logic [LRB-1:0] row_slot;            // row_count mod MAX_KSIZE
  logic [RB-1:0] r0;
  logic [CB-1:0] c0;
  logic          fend;

  // window walk counters and line slot of the current tap row
  logic [NB-1:0] wc;
  logic [KB-1:0] wi, wj;
  logic [LRB-1:0] wslot, r0_slot;
  logic          walk_last;

  logic signed [SAMPLE_BITS-1:0] line_mem [LDEPTH];
  logic signed [SAMPLE_BITS-1:0] wt_mem   [WDEPTH];
  logic signed [SAMPLE_BITS-1:0] line_q, wt_q;
  logic signed [SAMPLE_BITS-1:0] sample;

  assign sample = value[SAMPLE_BITS-1:0];

  logic in_acc, cfg_acc, out_acc;
  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg.valid;
  assign out_acc = out_ch.valid && out_ch.ready;

  // effective position after first / out-of-range wrap
  logic          pos_reset;
  logic [RB-1:0] er;
  logic [CB-1:0] ec;
  logic [NB-1:0] ech;
  logic [LRB-1:0] eslot;
  logic          last_ch, win_ok;
  always_comb begin
    pos_reset = first || row_count >= hcfg || col_count >= wcfg || chan_count >= ncfg;
    er    = pos_reset ? '0 : row_count;
    ec    = pos_reset ? '0 : col_count;
    ech   = pos_reset ? '0 : chan_count;
    eslot = pos_reset ? '0 : row_slot;
    last_ch = (32'(ech) + 1 >= 32'(ncfg));
    win_ok  = (32'(er) + 1 >= 32'(kcfg)) && (32'(ec) + 1 >= 32'(kcfg));
  end

  logic [LAB-1:0] waddr_l, raddr_l;
  logic [WAB-1:0] waddr_w, raddr_w;
  logic           wt_ok;
  always_comb begin
    waddr_l = LAB'((32'(eslot) * MAX_WIDTH + 32'(ec)) * MAX_CHANNELS + 32'(ech));
    raddr_l = LAB'((32'(wslot) * MAX_WIDTH + 32'(c0) + 32'(wj)) * MAX_CHANNELS
                   + 32'(wc));
    wt_ok   = 32'(wch) < MAX_CHANNELS && 32'(wrw) < MAX_KSIZE && 32'(wcl) < MAX_KSIZE;
    waddr_w = WAB'((32'(wch) * MAX_KSIZE + 32'(wrw)) * MAX_KSIZE + 32'(wcl));
    raddr_w = WAB'((32'(wc) * MAX_KSIZE + 32'(wi)) * MAX_KSIZE + 32'(wj));
  end

  always_ff @(posedge clk) begin
    if (in_acc && !mode) line_mem[waddr_l] <= sample;
    if (in_acc && mode && wt_ok) wt_mem[waddr_w] <= sample;
    line_q <= line_mem[raddr_l];
    wt_q   <= wt_mem[raddr_w];
  end

  assign walk_last = (32'(wj) + 1 == 32'(kcfg)) && (32'(wi) + 1 == 32'(kcfg))
                     && (32'(wc) + 1 == 32'(ncfg));

  // fetch-valid pipeline: read regs, product reg, then accumulate
  logic v1, v2;
  mac_ctl_t ctl;
  logic signed [SUM_BITS-1:0] acc;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && !mode && last_ch && win_ok) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_MAC;
      ST_MAC:   if (walk_last) state_next = ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_OUT;
      ST_OUT:   if (out_acc) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.clear  = (state == ST_FETCH);
    ctl.mac_en = v2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      state <= state_next;
      v1 <= (state == ST_MAC);
      v2 <= v1;
    end
  end

  // window walk: channel outer, kernel row, kernel column inner
  // r0_slot is loaded at the accepting edge, so the walk picks it up in FETCH
  always_ff @(posedge clk) begin
    if (state == ST_IDLE || state == ST_FETCH) begin
      wc <= '0; wi <= '0; wj <= '0;
      wslot <= r0_slot;
    end else if (state == ST_MAC) begin
      if (32'(wj) + 1 < 32'(kcfg)) begin
        wj <= wj + 1'b1;
      end else begin
        wj <= '0;
        if (32'(wi) + 1 < 32'(kcfg)) begin
          wi <= wi + 1'b1;
          wslot <= (32'(wslot) == MAX_KSIZE - 1) ? '0 : wslot + 1'b1;
        end else begin
          wi <= '0;
          wc <= wc + 1'b1;
          wslot <= r0_slot;
        end
      end
    end
  end

  // position counters and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0; col_count <= '0; chan_count <= '0; row_slot <= '0;
      image_width <= 9'd256; image_height <= 9'd256;
      kernel_side <= 3'd3; channel_count <= 3'd1;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg.index))
        REG_WIDTH:    image_width   <= cfg.wdata;
        REG_HEIGHT:   image_height  <= cfg.wdata;
        REG_KSIZE:    kernel_side   <= cfg.wdata[2:0];
        REG_CHANNELS: channel_count <= cfg.wdata[2:0];
        default: ;
      endcase
      row_count <= '0; col_count <= '0; chan_count <= '0; row_slot <= '0;
    end else if (in_acc && !mode) begin
      if (!last_ch) begin
        row_count <= er; col_count <= ec; row_slot <= eslot;
        chan_count <= ech + 1'b1;
      end else begin
        chan_count <= '0;
        if (32'(ec) + 1 < 32'(wcfg)) begin
          row_count <= er; row_slot <= eslot;
          col_count <= ec + 1'b1;
        end else begin
          col_count <= '0;
          if (32'(er) + 1 < 32'(hcfg)) begin
            row_count <= er + 1'b1;
            row_slot  <= (32'(eslot) == MAX_KSIZE - 1) ? '0 : eslot + 1'b1;
          end else begin
            row_count <= '0; row_slot <= '0;
          end
        end
      end
    end
  end

  // window origin, captured at the triggering pixel
  logic [LRB-1:0] back;
  always_comb begin
    back = LRB'(32'(kcfg) - 1);
  end
  always_ff @(posedge clk) begin
    if (in_acc && !mode && last_ch && win_ok) begin
      r0 <= RB'(32'(er) + 1 - 32'(kcfg));
      c0 <= CB'(32'(ec) + 1 - 32'(kcfg));
      fend <= (32'(er) + 1 == 32'(hcfg)) && (32'(ec) + 1 == 32'(wcfg));
      r0_slot <= (eslot >= back) ? LRB'(eslot - back)
                                 : LRB'(32'(eslot) + MAX_KSIZE - 32'(back));
    end
  end

  mcc_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk(clk), .ctl(ctl), .a(line_q), .b(wt_q), .acc(acc)
  );

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.data  = {acc, 8'(r0), 8'(c0), fend};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !out_ch.ready |=> $stable(acc)) else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |=> state == ST_MAC) else $error("bad fetch");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> !v1 && !v2) else $error("output before drain");
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import mcc_pkg::*;

  localparam int IN_BITS   = 26;
  localparam int OUT_BITS  = 57;
  localparam int SETTLE    = 4 * 49 + 4 + 10;
  localparam int WATCHDOG  = 20000;
  localparam int ITEM_GOAL = 1750;
  localparam int LINE_SLOTS = MAX_KSIZE_D * MAX_WIDTH_D * MAX_CHANNELS_D;
  localparam int COEF_SLOTS = MAX_CHANNELS_D * MAX_KSIZE_D * MAX_KSIZE_D;
  localparam logic MODE_PIXEL  = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] value;
    logic               first;
    logic [1:0]         wch;
    logic [2:0]         wrow;
    logic [2:0]         wcol;
  } pix_item_t;

  typedef struct packed {
    logic signed [39:0] conv_sum;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic               frame_end;
  } conv_res_t;

  typedef struct {
    pix_item_t it;
    bit        has_res;
    conv_res_t res;
  } dir_row_t;

  logic clk;
  logic rst;

  mcc_stream_if #(IN_BITS)  in_ch();
  mcc_stream_if #(OUT_BITS) out_ch();
  mcc_cfg_if #(CFG_IDX_BITS, CFG_DATA_BITS) cfg();

  multichannel_conv2d_core dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // predictor state
  logic signed [15:0] line_mem[LINE_SLOTS];
  logic signed [15:0] coef_mem[COEF_SLOTS];
  int unsigned pos_row, pos_col, pos_ch;
  int unsigned reg_w, reg_h, reg_k, reg_nc;

  conv_res_t pending_sums[$];
  int errors = 0;
  int sent;
  bit no_gaps;
  int out_stall;
  int idle_cycles = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned line_at(int unsigned r, int unsigned c, int unsigned ch);
    return ((r % MAX_KSIZE_D) * MAX_WIDTH_D + c) * MAX_CHANNELS_D + ch;
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [8:0] v);
    case (idx)
      REG_WIDTH:    reg_w = 32'(v);
      REG_HEIGHT:   reg_h = 32'(v);
      REG_KSIZE:    reg_k = 32'(v[2:0]);
      REG_CHANNELS: reg_nc = 32'(v[2:0]);
      default: ;
    endcase
    pos_row = 0; pos_col = 0; pos_ch = 0;
  endfunction

  function automatic bit conv_step(input pix_item_t it, output conv_res_t r);
    int unsigned w, h, k, nc, r0, c0;
    longint acc;
    bit hit;
    w  = clampu(reg_w, MAX_WIDTH_D);
    h  = clampu(reg_h, MAX_HEIGHT_D);
    k  = clampu(reg_k, MAX_KSIZE_D);
    nc = clampu(reg_nc, MAX_CHANNELS_D);
    hit = 0;
    r = '0;
    if (it.mode == MODE_WEIGHT) begin
      if (it.wrow < MAX_KSIZE_D && it.wcol < MAX_KSIZE_D)
        coef_mem[(it.wch * MAX_KSIZE_D + it.wrow) * MAX_KSIZE_D + it.wcol] = it.value;
      return 0;
    end
    if (it.first || pos_row >= h || pos_col >= w || pos_ch >= nc) begin
      pos_row = 0; pos_col = 0; pos_ch = 0;
    end
    line_mem[line_at(pos_row, pos_col, pos_ch)] = it.value;
    if (pos_ch + 1 < nc) begin
      pos_ch++;
      return 0;
    end
    if (pos_row + 1 >= k && pos_col + 1 >= k) begin
      r0 = pos_row + 1 - k;
      c0 = pos_col + 1 - k;
      acc = 0;
      for (int c = 0; c < nc; c++)
        for (int i = 0; i < k; i++)
          for (int j = 0; j < k; j++)
            acc += longint'(line_mem[line_at(r0 + i, c0 + j, c)]) *
                   longint'(coef_mem[(c * MAX_KSIZE_D + i) * MAX_KSIZE_D + j]);
      r.conv_sum  = acc[39:0];
      r.out_row   = r0[7:0];
      r.out_col   = c0[7:0];
      r.frame_end = (pos_row + 1 == h && pos_col + 1 == w);
      hit = 1;
    end
    pos_ch = 0;
    if (pos_col + 1 < w) begin
      pos_col++;
    end else begin
      pos_col = 0;
      pos_row = (pos_row + 1 < h) ? pos_row + 1 : 0;
    end
    return hit;
  endfunction

  function automatic pix_item_t mk(logic mode, logic signed [15:0] value, logic first,
                                   logic [1:0] wch, logic [2:0] wrow, logic [2:0] wcol);
    pix_item_t it;
    it.mode = mode; it.value = value; it.first = first;
    it.wch = wch; it.wrow = wrow; it.wcol = wcol;
    return it;
  endfunction

  function automatic conv_res_t mkres(longint s, int unsigned row, int unsigned col,
                                      bit fe);
    conv_res_t r;
    r.conv_sum = s[39:0]; r.out_row = row[7:0]; r.out_col = col[7:0]; r.frame_end = fe;
    return r;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH t=%0t %s", $time, msg);
    errors++;
  endtask

  // hand one item to the block; the typed result replaces the prediction when given
  task automatic send_item(input pix_item_t it, input bit typed = 0,
                           input bit typed_has = 0, input conv_res_t typed_res = '0);
    int gap;
    conv_res_t r;
    bit hit;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    hit = conv_step(it, r);
    if (typed) begin
      if (typed_has) pending_sums.insert(pending_sums.size(), typed_res);
    end else if (hit) begin
      pending_sums.insert(pending_sums.size(), r);
    end
    sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [8:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= v;
    do @(posedge clk); while (!cfg.ready);
    apply_reg(idx, v);
  endtask

  // block must be idle before any register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, logic [8:0] k, logic [8:0] nc);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_KSIZE, k);
    write_reg(REG_CHANNELS, nc);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_frames(int frames);
    int unsigned w, h, nc;
    pix_item_t it;
    w  = clampu(reg_w, MAX_WIDTH_D);
    h  = clampu(reg_h, MAX_HEIGHT_D);
    nc = clampu(reg_nc, MAX_CHANNELS_D);
    for (int f = 0; f < frames; f++) begin
      for (int p = 0; p < w * h * nc; p++) begin
        if ($urandom_range(0, 11) == 0) begin
          it = mk(MODE_WEIGHT, pick_value(), 1'($urandom), 2'($urandom),
                  3'($urandom), 3'($urandom));
          send_item(it);
        end
        it = mk(MODE_PIXEL, pick_value(),
                (p == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0),
                2'($urandom), 3'($urandom), 3'($urandom));
        send_item(it);
      end
    end
  endtask

  // result side: random stalls, compare against oldest prediction
  always @(posedge clk) begin
    conv_res_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_sums.size() == 0) begin
          report($sformatf("unexpected transaction sum=%0d", got.conv_sum));
        end else begin
          want = pending_sums.pop_front();
          if (got.conv_sum !== want.conv_sum)
            report($sformatf("conv_sum %0d, want %0d", got.conv_sum, want.conv_sum));
          if (got.out_row !== want.out_row)
            report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
          if (got.out_col !== want.out_col)
            report($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
          if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end %0b, want %0b", got.frame_end, want.frame_end));
        end
        out_stall = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= REG_WIDTH;
    cfg.wdata   <= '0;
    rst <= 1'b1;
    sent = 0; no_gaps = 0;
    pos_row = 0; pos_col = 0; pos_ch = 0;
    reg_w = 256; reg_h = 256; reg_k = 3; reg_nc = 1;

    // after reset: 256x256, K=3, so the first pixels give nothing
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh7fff, 1'b1, 2'd3, 3'd7, 3'd7),
                                       0, '0});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh8000, 1'b0, 2'd0, 3'd0, 3'd0),
                                       0, '0});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh0001, 1'b0, 2'd1, 3'd2, 3'd4),
                                       0, '0});
    // 2x1 image, K=1, one channel; first on a weight load is ignored
    dir_rows.insert(dir_rows.size(), '{mk(MODE_WEIGHT, 16'sh8000, 1'b1, 2'd0, 3'd0, 3'd0),
                                       0, '0});
    // weight addresses out of range do nothing
    dir_rows.insert(dir_rows.size(), '{mk(MODE_WEIGHT, 16'sh0005, 1'b0, 2'd0, 3'd7, 3'd0),
                                       0, '0});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_WEIGHT, 16'sh0005, 1'b0, 2'd0, 3'd0, 3'd7),
                                       0, '0});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh8000, 1'b1, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(64'sd1073741824, 0, 0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh7fff, 1'b0, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(-64'sd1073709056, 0, 1, 1)});
    // frame wraps
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh0001, 1'b0, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(-64'sd32768, 0, 0, 0)});
    // restart mid-frame
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh0000, 1'b1, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(64'sd0, 0, 0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'shffff, 1'b0, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(64'sd32768, 0, 1, 1)});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_WEIGHT, 16'sh7fff, 1'b0, 2'd0, 3'd0, 3'd0),
                                       0, '0});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh7fff, 1'b0, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(64'sd1073676289, 0, 0, 0)});
    dir_rows.insert(dir_rows.size(), '{mk(MODE_PIXEL, 16'sh8000, 1'b0, 2'd0, 3'd0, 3'd0), 1,
                                       mkres(-64'sd1073709056, 0, 1, 1)});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == 3) begin
        // fill every coefficient so no window reads an unwritten one
        settle();
        for (int c = 0; c < MAX_CHANNELS_D; c++)
          for (int r = 0; r < MAX_KSIZE_D; r++)
            for (int k = 0; k < MAX_KSIZE_D; k++)
              send_item(mk(MODE_WEIGHT, pick_value(), 1'($urandom), 2'(c), 3'(r), 3'(k)));
        configure(9'd2, 9'd1, 9'd1, 9'd1);
      end
      send_item(dir_rows[i].it, 1, dir_rows[i].has_res, dir_rows[i].res);
    end

    // extremes: full width, full height (raw values above range), largest kernel
    no_gaps = 1;
    configure(9'd511, 9'd1, 9'd1, 9'd1);
    run_frames(1);
    no_gaps = 0;
    configure(9'd1, 9'd300, 9'd1, 9'd1);
    run_frames(1);
    configure(9'd7, 9'd7, 9'd7, 9'd4);
    run_frames(1);
    // zero writes saturate up to one
    configure(9'd0, 9'd0, 9'd0, 9'd0);
    run_frames(2);

    while (sent < ITEM_GOAL) begin
      logic [8:0] w, h, k, nc;
      w  = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 9));
      h  = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 9));
      k  = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 7));
      nc = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(5, 7))
                                       : 9'($urandom_range(0, 4));
      no_gaps = ($urandom_range(0, 4) == 0);
      configure(w, h, k, nc);
      run_frames($urandom_range(1, 2));
    end

    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

[files.f]
src/mcc_pkg.sv
src/mcc_if.sv
src/mcc_mac.sv
src/multichannel_conv2d_core.sv
tb/sv/tb_top.sv
